FILE: src/tcf_pkg.sv
// Shared constants, command/status structs and the CORDIC angle table
// for the tilt complementary filter. No dependencies.
package tcf_pkg;

    localparam int WindowLen = 10;
    localparam int IdxW = $clog2(WindowLen);
    localparam int SumW = 20;
    localparam int SqW = 41;       // sum of two squares of 20-bit values
    localparam int RootW = 21;
    localparam int CordW = 40;     // CORDIC x/y width
    localparam int ZW = 26;        // CORDIC angle accumulator
    localparam int AngW = 24;
    localparam int CordSteps = 16;
    localparam logic [16:0] WeightReset = 17'd62915;
    localparam logic [16:0] WeightOne = 17'd65536;
    localparam logic signed [AngW-1:0] AngMax = 24'sh7FFFFF;
    localparam logic signed [AngW-1:0] AngMin = -24'sh800000;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // take input item, update window and sums
        logic sq_start;    // form squared magnitude for the current axis
        logic sqrt_step;   // one root digit
        logic cord_init;   // load CORDIC operands
        logic cord_step;   // one CORDIC rotation
        logic gyro_mul;    // rate * dt
        logic gyro_div;    // one of the two /250 steps
        logic gyro_sat;    // saturate gyro angle
        logic blend_mul;   // weighted products
        logic blend_fin;   // sum, round, store state
        logic [1:0] axis;  // 0 pitch, 1 roll, 2 yaw
    } tcf_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cord_done;
        logic div_done;
    } tcf_status_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [3:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            4'd0:  v = 26'd2949120;
            4'd1:  v = 26'd1740967;
            4'd2:  v = 26'd919879;
            4'd3:  v = 26'd466945;
            4'd4:  v = 26'd234379;
            4'd5:  v = 26'd117304;
            4'd6:  v = 26'd58666;
            4'd7:  v = 26'd29335;
            4'd8:  v = 26'd14668;
            4'd9:  v = 26'd7334;
            4'd10: v = 26'd3667;
            4'd11: v = 26'd1833;
            4'd12: v = 26'd917;
            4'd13: v = 26'd458;
            4'd14: v = 26'd229;
            default: v = 26'd115;
        endcase
        return v;
    endfunction

endpackage

FILE: src/tcf_ctrl.sv
// Sequencer for the tilt filter: steps the datapath through a window update,
// then square root, CORDIC, gyro and blend for each of three axes. Uses tcf_pkg.
module tcf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_free,
    input  tcf_pkg::tcf_status_t status,
    output tcf_pkg::tcf_cmd_t    cmd,
    output logic                 busy,
    output logic                 result_done
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_CINI = 4'd3;
    localparam logic [3:0] S_CORD = 4'd4;
    localparam logic [3:0] S_GMUL = 4'd5;
    localparam logic [3:0] S_GDIV = 4'd6;
    localparam logic [3:0] S_GSAT = 4'd7;
    localparam logic [3:0] S_BMUL = 4'd8;
    localparam logic [3:0] S_BFIN = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        cmd         = '0;
        cmd.axis    = axis_reg;
        result_done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = 2'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                    state_next = S_CINI;
            end
            S_CINI:
            begin
                cmd.cord_init = 1'b1;
                state_next    = S_CORD;
            end
            S_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (status.cord_done)
                    state_next = S_GMUL;
            end
            S_GMUL:
            begin
                cmd.gyro_mul = 1'b1;
                state_next   = S_GDIV;
            end
            S_GDIV:
            begin
                cmd.gyro_div = 1'b1;
                if (status.div_done)
                    state_next = S_GSAT;
            end
            S_GSAT:
            begin
                cmd.gyro_sat = 1'b1;
                state_next   = S_BMUL;
            end
            S_BMUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_BFIN;
            end
            S_BFIN:
            begin
                cmd.blend_fin = 1'b1;
                if (axis_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    result_done = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3) else $error("axis out of range");
    a_fin_adv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.blend_fin && axis_reg != 2'd2 |=> state_reg == S_SQ)
        else $error("blend did not advance axis");
endmodule

FILE: src/tcf_datapath.sv
// Datapath of the tilt filter: window ring and sums, digit-serial root,
// iterative CORDIC, two-step /250 by reciprocal and the blend. Uses tcf_pkg.
module tcf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcf_pkg::tcf_cmd_t                    cmd,
    output tcf_pkg::tcf_status_t                 status,
    input  logic [16:0]                          weight,
    input  logic signed [15:0]                   accel_x,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   accel_z,
    input  logic signed [14:0]                   gyro_x,
    input  logic signed [14:0]                   gyro_y,
    input  logic signed [14:0]                   gyro_z,
    input  logic [31:0]                          timestamp_ms,
    output logic signed [tcf_pkg::AngW-1:0]      pitch_angle,
    output logic signed [tcf_pkg::AngW-1:0]      roll_angle,
    output logic signed [tcf_pkg::AngW-1:0]      yaw_angle
);

    localparam int SumW = tcf_pkg::SumW;
    localparam int AngW = tcf_pkg::AngW;
    localparam int CW   = tcf_pkg::CordW;
    localparam int ZW   = tcf_pkg::ZW;
    localparam int WL   = tcf_pkg::WindowLen;
    localparam int IW   = tcf_pkg::IdxW;
    localparam logic [31:0] Recip250 = 32'd2199023256;   // ceil(2^39 / 250)

    // window ring: each entry read only at the write pointer
    logic signed [15:0] win_x [WL];
    logic signed [15:0] win_y [WL];
    logic signed [15:0] win_z [WL];
    logic [WL-1:0] win_valid_reg;
    logic [IW-1:0] idx_reg;
    logic signed [SumW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [31:0] last_time_reg, dt_reg;
    logic signed [14:0] gx_reg, gy_reg, gz_reg;
    logic signed [AngW-1:0] st_reg [3];
    logic signed [AngW-1:0] blend_val;

    logic signed [15:0] old_x, old_y, old_z;
    assign old_x = win_valid_reg[idx_reg] ? win_x[idx_reg] : 16'sd0;
    assign old_y = win_valid_reg[idx_reg] ? win_y[idx_reg] : 16'sd0;
    assign old_z = win_valid_reg[idx_reg] ? win_z[idx_reg] : 16'sd0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_x[idx_reg] <= accel_x;
            win_y[idx_reg] <= accel_y;
            win_z[idx_reg] <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            gz_reg <= gyro_z;
            dt_reg <= timestamp_ms - last_time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= '0;
            idx_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            last_time_reg <= '0;
            st_reg[0]     <= '0;
            st_reg[1]     <= '0;
            st_reg[2]     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                win_valid_reg[idx_reg] <= 1'b1;
                idx_reg <= (idx_reg == IW'(WL - 1)) ? '0 : idx_reg + 1'b1;
                sum_x_reg <= sum_x_reg + SumW'(accel_x) - SumW'(old_x);
                sum_y_reg <= sum_y_reg + SumW'(accel_y) - SumW'(old_y);
                sum_z_reg <= sum_z_reg + SumW'(accel_z) - SumW'(old_z);
                last_time_reg <= timestamp_ms;
            end
            if (cmd.blend_fin)
                st_reg[cmd.axis] <= blend_val;
        end
    end

    // axis operand selection: a over sqrt(b^2 + c^2)
    logic signed [SumW-1:0] op_a, op_b, op_c;
    always_comb
    begin
        unique case (cmd.axis)
            2'd0:    begin op_a = sum_z_reg; op_b = sum_x_reg; op_c = sum_y_reg; end
            2'd1:    begin op_a = sum_x_reg; op_b = sum_y_reg; op_c = sum_z_reg; end
            default: begin op_a = sum_y_reg; op_b = sum_x_reg; op_c = sum_z_reg; end
        endcase
    end

    // squared magnitude, then root one digit a cycle
    logic [41:0] rem_reg;
    logic [20:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [41:0] trial;
    logic [41:0] bsq, csq;
    assign bsq = 42'(unsigned'(40'(op_b * op_b)));
    assign csq = 42'(unsigned'(40'(op_c * op_c)));
    assign trial = {root_reg, 2'b01} << (2 * sq_cnt_reg);

    logic [41:0] rem_top;
    assign rem_top = rem_reg >> (2 * sq_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_start)
        begin
            rem_reg    <= bsq + csq;
            root_reg   <= '0;
            sq_cnt_reg <= 5'd20;
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_top >= 42'({root_reg, 2'b01}))
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= {root_reg[19:0], 1'b1};
            end
            else
                root_reg <= {root_reg[19:0], 1'b0};
            if (sq_cnt_reg != 5'd0)
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
        end
    end
    assign status.sqrt_done = cmd.sqrt_step && (sq_cnt_reg == 5'd0);

    // CORDIC vectoring
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [3:0] ci_reg;
    logic zero_reg;
    logic signed [CW-1:0] xs, ys;
    assign xs = cx_reg >>> ci_reg;
    assign ys = cy_reg >>> ci_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cord_init)
        begin
            cx_reg   <= CW'({1'b0, root_reg}) <<< 10;
            cy_reg   <= CW'(op_a) <<< 10;
            cz_reg   <= '0;
            ci_reg   <= '0;
            zero_reg <= (root_reg == '0) && (op_a == '0);
        end
        else if (cmd.cord_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + signed'(tcf_pkg::atan_entry(ci_reg));
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - signed'(tcf_pkg::atan_entry(ci_reg));
            end
            ci_reg <= ci_reg + 1'b1;
        end
    end
    assign status.cord_done = cmd.cord_step && (ci_reg == 4'd15);

    logic signed [ZW-1:0] zr;
    logic signed [AngW-1:0] acc_ang;
    assign zr = cz_reg + ZW'(128);
    assign acc_ang = zero_reg ? '0 : AngW'(zr >>> 8);

    // gyro: rate*dt + 125, floor-divided by 250 on the magnitude
    logic signed [14:0] rate;
    always_comb
    begin
        unique case (cmd.axis)
            2'd0:    rate = gx_reg;
            2'd1:    rate = gy_reg;
            default: rate = gz_reg;
        endcase
    end

    logic signed [47:0] prod;
    logic signed [47:0] nsum;
    assign prod = 48'(rate) * signed'({16'd0, dt_reg});
    assign nsum = prod + 48'sd125;

    // Split the magnitude m = mh*2^24 + ml. With 2^24 = 250*67108 + 216,
    // m/250 = mh*67108 + (mh*216 + ml)/250, and the low part stays below 2^31,
    // where floor(t * ceil(2^39/250) / 2^39) is exact.
    logic        neg_reg;
    logic [47:0] num_reg;   // magnitude, then quotient
    logic        dphase_reg;
    logic [31:0] dlow_reg;
    logic [47:0] dhigh_reg;
    logic [63:0] dlow_prod;
    assign dlow_prod = 64'(dlow_reg) * 64'(Recip250);

    always_ff @(posedge clk)
    begin
        if (cmd.gyro_mul)
        begin
            // floor(n/250) = n>=0 ? q : -floor((-n + 249)/250)
            neg_reg    <= nsum < 0;
            num_reg    <= (nsum < 0) ? 48'(-nsum + 48'sd249) : 48'(nsum);
            dphase_reg <= 1'b0;
        end
        else if (cmd.gyro_div)
        begin
            if (!dphase_reg)
            begin
                dlow_reg  <= 32'(num_reg[47:24] * 32'd216) + {8'd0, num_reg[23:0]};
                dhigh_reg <= 48'(num_reg[47:24]) * 48'd67108;
            end
            else
                num_reg <= dhigh_reg + 48'(dlow_prod[63:39]);
            dphase_reg <= 1'b1;
        end
    end
    assign status.div_done = cmd.gyro_div && dphase_reg;

    logic signed [48:0] gsum;
    logic signed [AngW-1:0] g_reg;
    assign gsum = 49'(st_reg[cmd.axis]) +
                  (neg_reg ? -signed'({1'b0, num_reg}) : signed'({1'b0, num_reg}));

    logic [16:0] w;
    assign w = (weight > tcf_pkg::WeightOne) ? tcf_pkg::WeightOne : weight;

    logic signed [42:0] pa_reg, pg_reg;
    logic signed [43:0] bsum;

    always_ff @(posedge clk)
    begin
        if (cmd.gyro_sat)
        begin
            if (gsum > 49'(tcf_pkg::AngMax))
                g_reg <= tcf_pkg::AngMax;
            else if (gsum < 49'(tcf_pkg::AngMin))
                g_reg <= tcf_pkg::AngMin;
            else
                g_reg <= AngW'(gsum);
        end
        if (cmd.blend_mul)
        begin
            pa_reg <= 43'(acc_ang) * signed'({1'b0, 17'(tcf_pkg::WeightOne - w)});
            pg_reg <= 43'(g_reg) * signed'({1'b0, w});
        end
    end

    assign bsum = 44'(pa_reg) + 44'(pg_reg) + 44'sd32768;
    assign blend_val = AngW'(bsum >>> 16);

    assign pitch_angle = st_reg[0];
    assign roll_angle  = st_reg[1];
    assign yaw_angle   = st_reg[2];

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < IW'(WL)) else $error("window index out of range");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.sq_start, cmd.sqrt_step, cmd.cord_init, cmd.cord_step,
                  cmd.gyro_mul, cmd.gyro_div, cmd.gyro_sat, cmd.blend_mul, cmd.blend_fin}))
        else $error("multiple datapath commands");
    a_div_low: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gyro_div && dphase_reg |-> !dlow_reg[31]) else $error("divider low part");
endmodule

FILE: src/tilt_complementary_filter.sv
// Tilt complementary filter top level. One sample at a time: accept, then for each
// of the three axes square, root digits, CORDIC load and rotation steps, multiply,
// the two-step divide, saturate and the blend multiply and finish, then output load.
// A full output register holds the input until it drains.
// Asynchronous active-low reset clears window, sums, timestamp and angles and
// restores gyro_weight to 62915.
module tilt_complementary_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[62:48],
    // gyro_y[77:63], gyro_z[92:78], timestamp_ms[124:93], zero pad
    input  logic [127:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pitch_angle[23:0], roll_angle[47:24], yaw_angle[71:48]
    output logic [71:0] m_axis_tdata
);

    logic [16:0] weight_reg;
    logic        in_fire, busy, result_done;
    logic        ovalid_reg;
    logic [71:0] odata_reg;
    tcf_pkg::tcf_cmd_t    cmd;
    tcf_pkg::tcf_status_t status;
    logic signed [23:0] pitch, roll, yaw;

    // hold the weight register; the host is to write it only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= tcf_pkg::WeightReset;
        else if (cfg_we)
            weight_reg <= cfg_wdata;
    end

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    tcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .out_free    (!ovalid_reg || m_axis_tready),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy),
        .result_done (result_done)
    );

    tcf_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .weight       (weight_reg),
        .accel_x      (s_axis_tdata[15:0]),
        .accel_y      (s_axis_tdata[31:16]),
        .accel_z      (s_axis_tdata[47:32]),
        .gyro_x       (s_axis_tdata[62:48]),
        .gyro_y       (s_axis_tdata[77:63]),
        .gyro_z       (s_axis_tdata[92:78]),
        .timestamp_ms (s_axis_tdata[124:93]),
        .pitch_angle  (pitch),
        .roll_angle   (roll),
        .yaw_angle    (yaw)
    );

    // output register: advance when the result finishes, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (result_done)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result_done)
            odata_reg <= {yaw, roll, pitch};
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy) else $error("accepted item not started");
    a_done_space: assert property (@(posedge clk) disable iff (!rst_n)
        result_done |-> (!ovalid_reg || m_axis_tready)) else $error("result overwrite");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule
